// File: rtl/core/kss_pkg.sv
`timescale 1ns / 1ps

package kss_pkg;

  // Field widths of the transactions
  localparam int unsigned KeyW    = 64;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 7;

  // Defaults
  localparam int unsigned StackDepthDef = 64;
  localparam logic [CountW-1:0] KeepCountRst = CountW'(10);

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_KEEP   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_EMIT     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EMIT   = 3'b010,
    S_SEARCH = 3'b100
  } state_e;

endpackage

// File: rtl/core/kss_if.sv
`timescale 1ns / 1ps

// Command channel: one transaction carries a command and a key
interface kss_cmd_if;
  import kss_pkg::*;

  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [KeyW-1:0]   key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

// Result channel: one transaction carries one result item
interface kss_res_if;
  import kss_pkg::*;

  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [KeyW-1:0]     entry;
  logic [CountW-1:0]   depth_after;
  logic                last;

  modport source (output valid, output status, output entry, output depth_after,
                  output last, input ready);
  modport sink   (input valid, input status, input entry, input depth_after,
                  input last, output ready);
endinterface

// File: rtl/core/kss_ram.sv
`timescale 1ns / 1ps

module kss_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/key_stack_with_search.sv
`timescale 1ns / 1ps

// Bounded LIFO stack of 64-bit keys with push, pop, keep-oldest and search.
// Commands arrive on cmd_i (valid/ready); results leave on res_o
// (valid/ready), one or more per command, the final one marked by last.
// keep_count is to be written by the user through cfg_we_i/cfg_wdata_i only
// while the block is idle; the block itself does not enforce this. The keys
// sit in a single-port-read, single-port-write RAM with a registered read;
// the read port sets the pace of the walking commands. Push and pop may
// follow each other every cycle while res_o is ready. Keep-oldest takes one
// RAM read for each emitted entry. Search compares the entries from the top
// down, dropping each miss; an empty stack is answered without a RAM read.
// A one-entry output register holds each result: a new command is taken in
// the cycle the waiting result leaves, so a stall on res_o holds the input,
// and it only freezes a walk at the point where it next has a result to hand
// over.
// Reset empties the stack and sets keep_count to 10; the RAM is not cleared,
// as only entries below the stack depth are ever read.
module key_stack_with_search #(
  parameter int unsigned STACK_DEPTH = kss_pkg::StackDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [kss_pkg::CountW-1:0] cfg_wdata_i,
  kss_cmd_if.sink                cmd_i,
  kss_res_if.source              res_o
);

  import kss_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DepthMax = DW'(STACK_DEPTH);

  state_e              state_q, state_d;
  logic [DW-1:0]       depth_q, depth_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [CountW-1:0]   keep_q;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [KeyW-1:0]     out_entry_q, out_entry_d;
  logic [CountW-1:0]   out_depth_q, out_depth_d;
  logic                out_last_q, out_last_d;

  logic                out_free;
  logic                accept;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [KeyW-1:0]     ram_rdata;
  logic [DW-1:0]       depth_dec;
  logic [DW-1:0]       keep_trunc;

  kss_ram #(
    .Width (KeyW),
    .Depth (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.key),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output slot can take a result this cycle
  assign out_free     = !out_valid_q || res_o.ready;
  assign cmd_i.ready  = (state_q == S_IDLE) && out_free;
  assign accept       = cmd_i.valid && cmd_i.ready;
  assign depth_dec    = depth_q - DW'(1);
  assign keep_trunc   = (CountW'(depth_q) > keep_q) ? DW'(keep_q) : depth_q;

  // Command sequencer
  always_comb begin
    state_d      = state_q;
    depth_d      = depth_q;
    idx_d        = idx_q;
    key_d        = key_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_depth_d  = out_depth_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = depth_q[AW-1:0];
    ram_re       = 1'b0;
    ram_raddr    = depth_dec[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          out_entry_d = '0;
          out_last_d  = 1'b1;
          key_d       = cmd_i.key;
          case (cmd_e'(cmd_i.command))
            CMD_PUSH: begin
              if (depth_q == DepthMax) begin
                out_status_d = ST_FULL;
                out_depth_d  = CountW'(depth_q);
              end else begin
                ram_we       = 1'b1;
                depth_d      = depth_q + DW'(1);
                out_status_d = ST_OK;
                out_depth_d  = CountW'(depth_d);
              end
            end
            CMD_POP: begin
              if (depth_q == '0) begin
                out_status_d = ST_EMPTY;
                out_depth_d  = '0;
              end else begin
                depth_d      = depth_dec;
                out_status_d = ST_OK;
                out_depth_d  = CountW'(depth_dec);
              end
            end
            CMD_KEEP: begin
              depth_d = keep_trunc;
              if (keep_trunc == '0) begin
                out_status_d = ST_EMPTY;
                out_depth_d  = '0;
              end else begin
                // Start the walk from the bottom entry
                out_valid_d = 1'b0;
                ram_re      = 1'b1;
                ram_raddr   = '0;
                idx_d       = '0;
                state_d     = S_EMIT;
              end
            end
            default: begin
              if (depth_q == '0) begin
                out_status_d = ST_NOTFOUND;
                out_depth_d  = '0;
              end else begin
                // Fetch the top entry for comparison
                out_valid_d = 1'b0;
                ram_re      = 1'b1;
                state_d     = S_SEARCH;
              end
            end
          endcase
        end
      end

      S_EMIT: begin
        // Hand over the fetched entry and fetch the next one up
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_EMIT;
          out_entry_d  = ram_rdata;
          out_depth_d  = CountW'(depth_q);
          out_last_d   = (DW'(idx_q) == depth_dec);
          if (DW'(idx_q) == depth_dec) begin
            state_d = S_IDLE;
          end else begin
            idx_d     = idx_q + AW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q + AW'(1);
          end
        end
      end

      S_SEARCH: begin
        if (ram_rdata == key_q) begin
          // Match on top: report it and leave it in place
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_FOUND;
            out_entry_d  = ram_rdata;
            out_depth_d  = CountW'(depth_q);
            out_last_d   = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (depth_dec == '0) begin
          // Bottom reached without a match
          if (out_free) begin
            depth_d      = '0;
            out_valid_d  = 1'b1;
            out_status_d = ST_NOTFOUND;
            out_entry_d  = '0;
            out_depth_d  = '0;
            out_last_d   = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          // Drop the top and fetch the one below
          depth_d   = depth_dec;
          ram_re    = 1'b1;
          ram_raddr = AW'(depth_dec - DW'(1));
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      keep_q      <= KeepCountRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    key_q        <= key_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_depth_q  <= out_depth_d;
    out_last_q   <= out_last_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.entry       = out_entry_q;
  assign res_o.depth_after = out_depth_q;
  assign res_o.last        = out_last_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import kss_pkg::*;

  localparam int unsigned Depth     = StackDepthDef;
  localparam int unsigned HangLimit = 5000;
  localparam int unsigned SettleCyc = 8;
  localparam int unsigned TailCyc   = 80;
  localparam int unsigned HoldCyc   = 300;
  localparam int unsigned RandItems = 35;

  typedef struct {
    status_e           status;
    logic [KeyW-1:0]   entry;
    logic [CountW-1:0] depth_after;
    logic              last;
  } stack_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [CountW-1:0] cfg_wdata;

  kss_cmd_if cmd_ch ();
  kss_res_if res_ch ();

  key_stack_with_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd_ch),
    .res_o       (res_ch)
  );

  // Shadow copy of the stack and of keep_count
  logic [KeyW-1:0] shadow_keys [Depth];
  int unsigned     shadow_depth;
  int unsigned     shadow_keep;
  stack_result_t   expected_results [$];
  logic [KeyW-1:0] key_pool [8];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_len;
  int unsigned hold_seq;
  int unsigned fail_count;
  int unsigned cmd_count;
  int unsigned result_count;
  int unsigned status_seen [6];
  int unsigned stall_cycles = 0;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Queue one expected result, tagged with the current shadow depth
  task automatic add_result(status_e st, logic [KeyW-1:0] ent, logic lst);
    stack_result_t r;
    r.status      = st;
    r.entry       = ent;
    r.depth_after = CountW'(shadow_depth);
    r.last        = lst;
    expected_results.push_back(r);
  endtask

  // Apply one accepted command to the shadow stack
  task automatic stack_apply(cmd_e cmd, logic [KeyW-1:0] key);
    case (cmd)
      CMD_PUSH: begin
        if (shadow_depth >= Depth) begin
          add_result(ST_FULL, '0, 1'b1);
        end else begin
          shadow_keys[shadow_depth] = key;
          shadow_depth++;
          add_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_POP: begin
        if (shadow_depth == 0) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          shadow_depth--;
          add_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_KEEP: begin
        if (shadow_depth > shadow_keep) shadow_depth = shadow_keep;
        if (shadow_depth == 0) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_depth; i++)
            add_result(ST_EMIT, shadow_keys[i], (i + 1 == shadow_depth));
        end
      end
      default: begin
        while (shadow_depth > 0 && shadow_keys[shadow_depth-1] != key) shadow_depth--;
        if (shadow_depth == 0) add_result(ST_NOTFOUND, '0, 1'b1);
        else add_result(ST_FOUND, shadow_keys[shadow_depth-1], 1'b1);
      end
    endcase
  endtask

  // Offer one command after a random gap, hold it until taken
  task automatic send_cmd(cmd_e cmd, logic [KeyW-1:0] key);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.key     <= key;
    do @(posedge clk_i); while (!cmd_ch.ready);
    stack_apply(cmd, key);
    cmd_count++;
  endtask

  // Drop valid and wait for every pending result, then let the block settle
  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_keep(int unsigned value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= CountW'(value);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    shadow_keep = value;
  endtask

  function automatic logic [KeyW-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Mix pool keys in so that searches meet duplicates
  function automatic logic [KeyW-1:0] push_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return key_pool[$urandom_range(7)];
    if (roll < 33) return '0;
    if (roll < 36) return '1;
    return random_key();
  endfunction

  // Mostly search for a key that is on the stack
  function automatic logic [KeyW-1:0] search_key();
    if (shadow_depth > 0 && $urandom_range(99) < 80)
      return shadow_keys[$urandom_range(shadow_depth - 1)];
    return random_key();
  endfunction

  task automatic test_directed();
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_SEARCH, '0);
    send_cmd(CMD_KEEP, '1);
    send_cmd(CMD_PUSH, '0);
    send_cmd(CMD_PUSH, '1);
    send_cmd(CMD_PUSH, 64'hA5A5_A5A5_A5A5_A5A5);
    send_cmd(CMD_PUSH, 64'h5A5A_5A5A_5A5A_5A5A);
    // search drops two entries before the match
    send_cmd(CMD_SEARCH, '1);
    // depth below keep_count: nothing dropped, all emitted
    send_cmd(CMD_KEEP, '0);
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_PUSH, 64'h1);
    send_cmd(CMD_PUSH, 64'h8000_0000_0000_0000);
    send_cmd(CMD_SEARCH, '0);
    // match already on top
    send_cmd(CMD_SEARCH, '0);
    // miss empties the stack
    send_cmd(CMD_SEARCH, 64'h8000_0000_0000_0000);
    repeat (12) send_cmd(CMD_PUSH, random_key());
    // depth above keep_count: truncate, then emit
    send_cmd(CMD_KEEP, '0);
  endtask

  task automatic test_keep_count();
    write_keep(1);
    repeat (3) send_cmd(CMD_PUSH, random_key());
    send_cmd(CMD_KEEP, '0);
    send_cmd(CMD_KEEP, '0);
    write_keep(64);
    repeat (4) send_cmd(CMD_PUSH, random_key());
    send_cmd(CMD_KEEP, '0);
    write_keep($urandom_range(63, 2));
    send_cmd(CMD_KEEP, '0);
  endtask

  task automatic test_full_stack();
    write_keep(64);
    while (shadow_depth < Depth) send_cmd(CMD_PUSH, random_key());
    send_cmd(CMD_PUSH, '1);
    send_cmd(CMD_PUSH, '0);
    // longest emission, then the longest miss
    send_cmd(CMD_KEEP, '0);
    send_cmd(CMD_SEARCH, random_key());
    while (shadow_depth < Depth) send_cmd(CMD_PUSH, random_key());
    // walk down to the bottom entry
    send_cmd(CMD_SEARCH, shadow_keys[0]);
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_POP, '0);
  endtask

  // Stall the result side long enough for the input to back up
  task automatic test_backpressure();
    write_keep(64);
    hold_len = HoldCyc;
    hold_seq++;
    repeat (30) send_cmd(CMD_PUSH, push_key());
    send_cmd(CMD_KEEP, '0);
    send_cmd(CMD_SEARCH, search_key());
    send_cmd(CMD_SEARCH, search_key());
    repeat (4) send_cmd(CMD_POP, '0);
    wait_idle();
  endtask

  task automatic run_random(int unsigned n_items);
    int unsigned pick;
    for (int n = 0; n < n_items; n++) begin
      if (n % 25 == 24) begin
        pick = $urandom_range(3);
        if (pick == 0) write_keep(1);
        else if (pick == 1) write_keep(Depth);
        else write_keep($urandom_range(Depth, 1));
      end
      pick = $urandom_range(99);
      if (pick < 50) send_cmd(CMD_PUSH, push_key());
      else if (pick < 62) send_cmd(CMD_POP, random_key());
      else if (pick < 74) send_cmd(CMD_KEEP, random_key());
      else send_cmd(CMD_SEARCH, search_key());
    end
  endtask

  // Result side: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int unsigned hold_ack;
    int unsigned hold_left;
    hold_ack     = 0;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_ack) begin
        hold_ack  = hold_seq;
        hold_left = hold_len;
      end
      if (!rst_ni) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    stack_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d entry %h", res_ch.status, res_ch.entry);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        result_count++;
        status_seen[want.status]++;
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          fail_count++;
        end
        if (res_ch.entry !== want.entry) begin
          $error("entry: expected %h, got %h", want.entry, res_ch.entry);
          fail_count++;
        end
        if (res_ch.depth_after !== want.depth_after) begin
          $error("depth_after: expected %0d, got %0d", want.depth_after,
                 res_ch.depth_after);
          fail_count++;
        end
        if (res_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, res_ch.last);
          fail_count++;
        end
      end
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk_i) begin : hang_watch
    if (!rst_ni || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= HangLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.command = CMD_PUSH;
    cmd_ch.key     = '0;
    src_idle_pct   = 31;
    sink_idle_pct  = 78;
    hold_len       = 0;
    hold_seq       = 0;
    fail_count     = 0;
    cmd_count      = 0;
    result_count   = 0;
    shadow_depth   = 0;
    shadow_keep    = KeepCountRst;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (key_pool[i]) key_pool[i] = random_key();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_keep_count();
    run_random(RandItems);

    src_idle_pct  = 78;
    sink_idle_pct = 31;
    test_full_stack();
    run_random(RandItems);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_backpressure();
    run_random(RandItems);

    wait_idle();
    repeat (TailCyc) @(posedge clk_i);

    $display("covered %0d commands and %0d results, keep_count 1 to 64, empty and full stack",
             cmd_count, result_count);
    $display("results: ok %0d, full %0d, empty %0d, found %0d, not found %0d, emitted %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_FOUND], status_seen[ST_NOTFOUND], status_seen[ST_EMIT]);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
